// File: rtl/cgrt_pkg.sv
// Shared types and constants for the color gradient ramp table.
// Used by every module of the block but cgrt_ram; depends on nothing.
package cgrt_pkg;

  localparam int TABLE_LEVELS = 256;
  localparam int IDX_W        = $clog2(TABLE_LEVELS);
  localparam int LEVEL_W      = 8;
  localparam int COLOR_W      = 8;
  localparam int NUM_CH       = 3;
  localparam int CH_W         = $clog2(NUM_CH);
  localparam int ENTRY_W      = NUM_CH * COLOR_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int DIV_STEPS    = COLOR_W;

  // Channel slots inside a packed color; red sits in the top byte
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // Function codes of an input item
  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef color_t [NUM_CH-1:0] rgb_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_LOOKUP,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    level_t     level;
    color_t     red_in;
    color_t     green_in;
    color_t     blue_in;
  } cgrt_in_t;

  typedef struct packed {
    color_t red_out;
    color_t green_out;
    color_t blue_out;
  } cgrt_out_t;

  typedef struct packed {
    op_t    op;
    level_t level;
    rgb_t   color;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic   start;
    color_t dividend;
    color_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    color_t quotient;
    color_t remainder;
  } div_rsp_t;

  function automatic logic level_in_table(level_t lvl);
    return 32'(lvl) < TABLE_LEVELS;
  endfunction

endpackage

// File: rtl/cgrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module cgrt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cgrt_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp step sizes.
// Depends on cgrt_pkg.
module cgrt_div (
  input  logic               clk,
  input  logic               rst,
  input  cgrt_pkg::div_req_t dreq,
  output cgrt_pkg::div_rsp_t drsp
);
  import cgrt_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  color_t            quo;
  color_t            rem;
  color_t            dvs;
  logic [COLOR_W:0]  shifted;
  logic [COLOR_W:0]  diff;
  logic              ge;

  always_comb begin
    shifted = {rem, quo[COLOR_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dreq.dividend;
        rem  <= '0;
        dvs  <= dreq.divisor;
      end else if (busy) begin
        rem <= ge ? diff[COLOR_W-1:0] : shifted[COLOR_W-1:0];
        quo <= {quo[COLOR_W-2:0], ge};
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign drsp.done      = done;
  assign drsp.quotient  = quo;
  assign drsp.remainder = rem;

endmodule

// File: rtl/cgrt_front.sv
// Front end: accepts input items, decodes the function code, drops unused
// codes and hands commands to the queue. Depends on cgrt_pkg.
module cgrt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cgrt_pkg::cgrt_in_t   req,
  input  cgrt_pkg::back_stat_t stat,
  output logic                 cmd_valid,
  output cgrt_pkg::cmd_t       cmd,
  input  logic                 cmd_full
);
  import cgrt_pkg::*;

  logic accept;
  logic push;
  logic known;
  cmd_t cmd_next;

  always_comb begin
    push      = cmd_valid && !cmd_full;
    req_ready = !stat.clearing && (!cmd_valid || push);
    accept    = req_valid && req_ready;

    cmd_next.level = req.level;
    cmd_next.color = {req.red_in, req.green_in, req.blue_in};
    case (req.func)
      FUNC_ADD: begin
        known       = 1'b1;
        cmd_next.op = OP_ADD;
      end
      FUNC_LOOKUP: begin
        known       = 1'b1;
        cmd_next.op = OP_LOOKUP;
      end
      FUNC_RESTART: begin
        known       = 1'b1;
        cmd_next.op = OP_RESTART;
      end
      default: begin
        known       = 1'b0;
        cmd_next.op = OP_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      // drop unused codes here
      cmd_valid <= known;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// File: rtl/cgrt_fifo.sv
// Short command queue between the front end and the ramp engine.
// Depends on cgrt_pkg.
module cgrt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cgrt_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output cgrt_pkg::cmd_t pop_data,
  output logic           empty
);
  import cgrt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full     = count == CNT_W'(QUEUE_DEPTH);
    empty    = count == '0;
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_data = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/cgrt_back.sv
// Ramp engine: clears the palette after reset, runs control points through
// the divider and an incremental interpolator, serves lookups and restarts.
// Depends on cgrt_pkg; drives the palette RAM and the divider.
module cgrt_back (
  input  logic                   clk,
  input  logic                   rst,
  output logic                   pop,
  input  cgrt_pkg::cmd_t         pop_data,
  input  logic                   empty,
  output logic                   ram_we,
  output logic [cgrt_pkg::IDX_W-1:0] ram_waddr,
  output cgrt_pkg::rgb_t         ram_wdata,
  output logic [cgrt_pkg::IDX_W-1:0] ram_raddr,
  input  cgrt_pkg::rgb_t         ram_rdata,
  output cgrt_pkg::div_req_t     dreq,
  input  cgrt_pkg::div_rsp_t     drsp,
  output cgrt_pkg::back_stat_t   stat,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output cgrt_pkg::cgrt_out_t    rsp
);
  import cgrt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FILL,
    S_READ
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_addr;
  level_t           anchor_lvl;
  rgb_t             anchor_rgb;
  level_t           tgt_lvl;
  rgb_t             new_rgb;
  color_t           span;
  logic [CH_W-1:0]  ch;
  color_t           dq [NUM_CH];
  color_t           dr [NUM_CH];
  logic [NUM_CH-1:0] neg;
  rgb_t             q;
  color_t           r [NUM_CH];
  level_t           pos;

  logic             neg_ch;
  color_t           abs_ch;
  rgb_t             q_next;
  color_t           r_next [NUM_CH];
  logic [COLOR_W:0] s_pos;
  logic             carry;
  logic             borrow;
  logic             is_add;
  logic             is_lookup;

  // Absolute color difference of the channel under division
  always_comb begin
    neg_ch = new_rgb[ch] < anchor_rgb[ch];
    abs_ch = neg_ch ? anchor_rgb[ch] - new_rgb[ch] : new_rgb[ch] - anchor_rgb[ch];
  end

  // One interpolation step per channel: q + d/span with remainder tracking
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s_pos  = {1'b0, r[c]} + {1'b0, dr[c]};
      carry  = s_pos >= {1'b0, span};
      borrow = r[c] < dr[c];
      if (!neg[c]) begin
        r_next[c] = carry ? COLOR_W'(s_pos - {1'b0, span}) : s_pos[COLOR_W-1:0];
        q_next[c] = q[c] + dq[c] + {{(COLOR_W-1){1'b0}}, carry};
      end else begin
        r_next[c] = borrow ? r[c] + span - dr[c] : r[c] - dr[c];
        q_next[c] = q[c] - dq[c] - {{(COLOR_W-1){1'b0}}, borrow};
      end
    end
  end

  always_comb begin
    is_add    = pop_data.op == OP_ADD;
    is_lookup = pop_data.op == OP_LOOKUP;
    pop       = (state == S_IDLE) && !empty && (!is_lookup || !rsp_valid);

    ram_raddr = IDX_W'(pop_data.level);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_FILL: begin
        ram_we    = level_in_table(pos);
        ram_waddr = IDX_W'(pos);
        ram_wdata = q;
      end
      default: begin
        // a point at the anchor level is written directly
        ram_we    = pop && is_add && (pop_data.level == anchor_lvl)
                    && level_in_table(pop_data.level);
        ram_waddr = IDX_W'(pop_data.level);
        ram_wdata = pop_data.color;
      end
    endcase

    dreq.start    = state == S_DIV_GO;
    dreq.dividend = abs_ch;
    dreq.divisor  = span;

    stat.clearing = state == S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      anchor_lvl <= '0;
      anchor_rgb <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(TABLE_LEVELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            case (pop_data.op)
              OP_ADD: begin
                if (pop_data.level > anchor_lvl) begin
                  tgt_lvl <= pop_data.level;
                  new_rgb <= pop_data.color;
                  span    <= pop_data.level - anchor_lvl;
                  ch      <= CH_W'(NUM_CH - 1);
                  state   <= S_DIV_GO;
                end else begin
                  anchor_lvl <= pop_data.level;
                  anchor_rgb <= pop_data.color;
                end
              end
              OP_LOOKUP: begin
                if (level_in_table(pop_data.level)) begin
                  state <= S_READ;
                end else begin
                  rsp       <= '0;
                  rsp_valid <= 1'b1;
                end
              end
              OP_RESTART: begin
                anchor_lvl <= '0;
                anchor_rgb <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV_GO: begin
          neg[ch] <= neg_ch;
          state   <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (drsp.done) begin
            dq[ch] <= drsp.quotient;
            dr[ch] <= drsp.remainder;
            if (ch == '0) begin
              pos   <= anchor_lvl;
              q     <= anchor_rgb;
              for (int c = 0; c < NUM_CH; c++) begin
                r[c] <= '0;
              end
              state <= S_FILL;
            end else begin
              ch    <= ch - 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_FILL: begin
          if (pos == tgt_lvl) begin
            anchor_lvl <= tgt_lvl;
            anchor_rgb <= new_rgb;
            state      <= S_IDLE;
          end else begin
            pos <= pos + 1'b1;
            q   <= q_next;
            for (int c = 0; c < NUM_CH; c++) begin
              r[c] <= r_next[c];
            end
          end
        end
        S_READ: begin
          rsp.red_out   <= ram_rdata[CH_RED];
          rsp.green_out <= ram_rdata[CH_GREEN];
          rsp.blue_out  <= ram_rdata[CH_BLUE];
          rsp_valid     <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/color_gradient_ramp_table.sv
// Color gradient ramp table: a palette of TABLE_LEVELS RGB entries built by
// linear interpolation between control points. After reset the block sweeps
// the palette to black, one entry per cycle, and holds req_ready low
// meanwhile. Items are taken into a two-entry command queue, so the input
// side keeps accepting while the engine works, until the queue fills. A
// restart or a control point at or below the anchor is handled in S_IDLE
// alone; a lookup passes through S_IDLE and S_READ (registered palette
// read), and its result is registered behind the front register and queue.
// A control point above the anchor runs through the shared bit-serial
// divider, which finds each channel's step size in turn, and then through
// the interpolator, which writes one palette entry per cycle through the
// single RAM write port.
// Depends on cgrt_pkg and its submodules.
module color_gradient_ramp_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cgrt_pkg::cgrt_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cgrt_pkg::cgrt_out_t rsp
);
  import cgrt_pkg::*;

  back_stat_t       stat;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_full;
  logic             pop;
  cmd_t             pop_data;
  logic             empty;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rgb_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  rgb_t             ram_rdata;
  div_req_t         dreq;
  div_rsp_t         drsp;

  cgrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .stat      (stat),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_full  (cmd_full)
  );

  cgrt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data (cmd),
    .full      (cmd_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cgrt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  cgrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_LEVELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cgrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .dreq      (dreq),
    .drsp      (drsp),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: rtl/cgrt_checker.sv
// Port-level checks for the color gradient ramp table, bound to the top.
// Depends on cgrt_pkg.
module cgrt_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input cgrt_pkg::cgrt_in_t  req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input cgrt_pkg::cgrt_out_t rsp
);

  // palette sweep holds off input right after reset
  a_clear_blocks_input: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item accepted during palette clear");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("stalled input item changed or dropped");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

endmodule

bind color_gradient_ramp_table cgrt_checker u_cgrt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
